/* rtl/core/mlbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types, constants and helpers for the multi-LED blink controller.
// ----------------------------------------------------------------------------
package mlbc_pkg;

   localparam int LED_NUM   = 8;
   localparam int TIME_BITS = 16;
   localparam int IDX_W     = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0]     idx_type;

   typedef enum logic [2:0] {
      CMD_SET_LEVEL = 3'd0,
      CMD_ON        = 3'd1,
      CMD_OFF       = 3'd2,
      CMD_TOGGLE    = 3'd3,
      CMD_BLINK     = 3'd4,
      CMD_TICK      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_TOG   = 2'd2,
      MODE_BLINK = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_POLARITY  = 1'd0,
      CSR_TICK_STEP_MS = 1'd1
   } csr_idx_type;

   // One LED's stored context
   typedef struct packed {
      mode_type mode;
      logic     lit;
      time_type remaining;
      time_type lit_time;
      time_type dark_time;
   } entry_type;

   // Result of one update step
   typedef struct packed {
      logic      we;
      logic      pin_we;
      logic      pin_val;
      entry_type entry;
   } upd_type;

   function automatic time_type clamp_time(input logic [15:0] t);
      logic [31:0] w;
      w = 32'(t);
      if (w > 32'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return w[TIME_BITS-1:0];
   endfunction

   // Pin level that lights LED idx; LEDs past the mask light on level 1
   function automatic logic lit_level(input logic [7:0] pol, input idx_type idx);
      if (32'(idx) >= 8) begin
         return 1'b1;
      end
      return pol[3'(idx)];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/mlbc_led_upd.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlbc_led_upd
// Next-state logic for one LED entry: applies a command or one tick step.
// ----------------------------------------------------------------------------
module mlbc_led_upd (
   input  wire mlbc_pkg::cmd_type   op,
   input  wire mlbc_pkg::entry_type ent,
   input  wire logic                level,
   input  wire logic                lit_lvl,
   input  wire mlbc_pkg::time_type  on_time,
   input  wire mlbc_pkg::time_type  dark_ms,
   input  wire logic [7:0]          step,
   output mlbc_pkg::upd_type        upd
);
   import mlbc_pkg::*;

   time_type rem_sub;

   always_comb begin
      rem_sub = (ent.remaining > TIME_BITS'(step))
                ? ent.remaining - TIME_BITS'(step) : '0;

      upd.we      = 1'b0;
      upd.pin_we  = 1'b0;
      upd.pin_val = 1'b0;
      upd.entry   = ent;

      case (op)
         CMD_SET_LEVEL: begin
            upd.pin_we  = 1'b1;
            upd.pin_val = level;
         end
         CMD_ON: begin
            upd.we         = 1'b1;
            upd.entry.mode = MODE_ON;
            upd.pin_we     = 1'b1;
            upd.pin_val    = lit_lvl;
         end
         CMD_OFF: begin
            upd.we         = 1'b1;
            upd.entry.mode = MODE_OFF;
            upd.pin_we     = 1'b1;
            upd.pin_val    = ~lit_lvl;
         end
         CMD_TOGGLE: begin
            upd.we         = 1'b1;
            upd.entry.mode = MODE_TOG;
            upd.pin_we     = 1'b1;
            upd.pin_val    = ent.lit ? ~lit_lvl : lit_lvl;
            upd.entry.lit  = ~ent.lit;
         end
         CMD_BLINK: begin
            upd.we              = 1'b1;
            upd.entry.mode      = MODE_BLINK;
            upd.entry.lit       = 1'b1;
            upd.entry.remaining = on_time;
            upd.entry.lit_time  = on_time;
            upd.entry.dark_time = dark_ms;
            upd.pin_we          = 1'b1;
            upd.pin_val         = lit_lvl;
         end
         CMD_TICK: begin
            if (ent.mode == MODE_BLINK) begin
               upd.we              = 1'b1;
               upd.entry.remaining = rem_sub;
               if (rem_sub == '0) begin
                  upd.pin_we = 1'b1;
                  if (ent.lit) begin
                     upd.pin_val = ~lit_lvl;
                     if (ent.dark_time == '0) begin
                        // single blink done
                        upd.entry.mode = MODE_OFF;
                     end else begin
                        upd.entry.remaining = ent.dark_time;
                        upd.entry.lit       = 1'b0;
                     end
                  end else begin
                     upd.pin_val         = lit_lvl;
                     upd.entry.remaining = ent.lit_time;
                     upd.entry.lit       = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/multi_led_blink_controller_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_led_blink_controller_top
// Per-LED on/off/toggle/blink control with a shared tick, context in RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request yields
// exactly one response, shown for a single cycle with rsp_valid high, and the
// receiver cannot stall it. The context RAM read is issued at the accept edge.
// Set level, on, off, toggle and blink pass through ST_CMD (the update step)
// and then ST_RESP, which puts the strobe up; a tick walks all LED_NUM
// entries through the context RAM one per cycle in ST_TICK, then goes to
// ST_RESP. Requests with an unused command code or an LED index out of range
// go straight from idle to ST_RESP.
// busy stays high through the response cycle, so the next request can be
// taken in the cycle after the strobe. CSR writes are expected while idle.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [2:0]  req_led,
   input  wire logic        req_level,
   input  wire logic [15:0] req_on_time_ms,
   input  wire logic [15:0] req_off_time_ms,
   // configuration
   input  wire logic        csr_write_en,
   input  wire logic [mlbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]  csr_data,
   // response channel
   output logic             rsp_valid,
   output logic [7:0]       rsp_pin_levels,
   output logic [7:0]       rsp_blinking
);
   import mlbc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_TICK,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;
   cmd_type   cmd_ff, cmd_in;
   logic      level_ff, level_in;
   time_type  on_ff, on_in;
   time_type  off_ff, off_in;

   logic [7:0] polarity_ff;
   logic [7:0] step_ff;

   logic [LED_NUM-1:0] pin_ff, pin_in;
   logic [LED_NUM-1:0] blink_ff, blink_in;

   // Context RAM; valid bits stand in for the reset value of each entry
   entry_type          ctx_mem [LED_NUM];
   logic [LED_NUM-1:0] valid_ff;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;
   entry_type          rd_entry;

   cmd_type   op;
   upd_type   upd;
   logic      in_range;
   logic      upd_active;
   logic      last_idx;

   assign in_range   = 32'(req_led) < LED_NUM;
   assign rd_entry   = rd_valid_ff ? rd_data_ff : '0;
   assign op         = (state_ff == ST_TICK) ? CMD_TICK : cmd_ff;
   assign upd_active = (state_ff == ST_CMD) || (state_ff == ST_TICK);
   assign last_idx   = (idx_ff == IDX_W'(LED_NUM - 1));

   mlbc_led_upd u_upd (
      .op       (op),
      .ent      (rd_entry),
      .level    (level_ff),
      .lit_lvl  (lit_level(polarity_ff, idx_ff)),
      .on_time  (on_ff),
      .dark_ms  (off_ff),
      .step     (step_ff),
      .upd      (upd)
   );

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd_in   = cmd_ff;
      level_in = level_ff;
      on_in    = on_ff;
      off_in   = off_ff;
      pin_in   = pin_ff;
      blink_in = blink_ff;

      if (upd_active) begin
         if (upd.pin_we) begin
            pin_in[idx_ff] = upd.pin_val;
         end
         if (upd.we) begin
            blink_in[idx_ff] = (upd.entry.mode == MODE_BLINK);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_command);
               level_in = req_level;
               on_in    = clamp_time(req_on_time_ms);
               off_in   = clamp_time(req_off_time_ms);
               if (cmd_type'(req_command) == CMD_TICK) begin
                  idx_in   = '0;
                  state_in = ST_TICK;
               end else if (req_command <= 3'(CMD_BLINK) && in_range) begin
                  idx_in   = IDX_W'(req_led);
                  state_in = ST_CMD;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_CMD: begin
            state_in = ST_RESP;
         end
         ST_TICK: begin
            // read of the next entry overlaps the write-back of this one
            if (last_idx) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // FSM, request latch, CSR and pin/blink registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pin_ff      <= '0;
         blink_ff    <= '0;
         polarity_ff <= 8'hFF;
         step_ff     <= 8'd10;
      end else begin
         state_ff <= state_in;
         pin_ff   <= pin_in;
         blink_ff <= blink_in;
         if (csr_write_en) begin
            case (csr_idx_type'(csr_index))
               CSR_ON_POLARITY:  polarity_ff <= csr_data;
               CSR_TICK_STEP_MS: step_ff     <= csr_data;
               default: begin
               end
            endcase
         end
      end
      idx_ff   <= idx_in;
      cmd_ff   <= cmd_in;
      level_ff <= level_in;
      on_ff    <= on_in;
      off_ff   <= off_in;
   end

   // Valid bits per RAM entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[idx_in];
         if (upd_active && upd.we) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Context RAM: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (upd_active && upd.we) begin
         ctx_mem[idx_ff] <= upd.entry;
      end
      rd_data_ff <= ctx_mem[idx_in];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_pin_levels = 8'(pin_ff);
   assign rsp_blinking   = 8'(blink_ff);

endmodule
`default_nettype wire

/* test/multi_led_blink_controller_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_led_blink_controller_top_tb
// Self-checking bench for the LED blink controller. A directed table covers
// every command, the field extremes and the corner cases. Random traffic then
// runs under several polarity and tick step settings. Each response is checked
// against the table's known answer or a cycle-free model of the LED row.
// ----------------------------------------------------------------------------
module multi_led_blink_controller_top_tb;
   import mlbc_pkg::*;

   // command codes the block does not use; they must leave all state alone
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;

   localparam int STALL_LIMIT     = 2000;  // cycles with no traffic at all
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int MAX_SHOWN       = 10;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  led;
      logic        level;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } led_req_type;

   typedef struct packed {
      logic [7:0] pin_levels;
      logic [7:0] blinking;
   } led_status_type;

   // typed = 1: status is the known answer, otherwise the model decides
   typedef struct packed {
      led_req_type    req;
      logic           typed;
      led_status_type status;
   } directed_row_type;

   // Reset state: polarity FF (lit = 1), tick step 10 ms, all pins low.
   localparam directed_row_type DIRECTED_ROWS [0:24] = '{
      // set level writes the raw pin, extremes of the LED index
      '{'{CMD_SET_LEVEL, 3'd0, 1'b1, 16'h0000, 16'h0000}, 1'b1, '{8'h01, 8'h00}},
      '{'{CMD_SET_LEVEL, 3'd7, 1'b1, 16'h0000, 16'h0000}, 1'b1, '{8'h81, 8'h00}},
      '{'{CMD_SET_LEVEL, 3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h80, 8'h00}},
      // on and off keep the lit flag, so the toggles work from the flag
      '{'{CMD_ON,        3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h88, 8'h00}},
      '{'{CMD_OFF,       3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h80, 8'h00}},
      '{'{CMD_TOGGLE,    3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h88, 8'h00}},
      '{'{CMD_TOGGLE,    3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h80, 8'h00}},
      '{'{CMD_ON,        3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h88, 8'h00}},
      '{'{CMD_TOGGLE,    3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h88, 8'h00}},
      '{'{CMD_OFF,       3'd3, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h80, 8'h00}},
      // unused codes change nothing but still answer
      '{'{CMD_RSVD6,     3'd2, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'h80, 8'h00}},
      '{'{CMD_RSVD7,     3'd5, 1'b1, 16'hFFFF, 16'h0000}, 1'b1, '{8'h80, 8'h00}},
      // longest blink, and a one-shot blink (dark time zero)
      '{'{CMD_BLINK,     3'd1, 1'b0, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'h82, 8'h02}},
      '{'{CMD_BLINK,     3'd2, 1'b0, 16'd20,   16'h0000}, 1'b1, '{8'h86, 8'h06}},
      '{'{CMD_TICK,      3'd2, 1'b1, 16'h1234, 16'h4321}, 1'b1, '{8'h86, 8'h06}},
      '{'{CMD_TICK,      3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h82, 8'h02}},
      // zero lit and dark time: gone after the first tick
      '{'{CMD_BLINK,     3'd4, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h92, 8'h12}},
      '{'{CMD_TICK,      3'd7, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'h82, 8'h02}},
      // raw level on a blinking LED keeps it blinking
      '{'{CMD_SET_LEVEL, 3'd1, 1'b0, 16'h0000, 16'h0000}, 1'b1, '{8'h80, 8'h02}},
      '{'{CMD_BLINK,     3'd6, 1'b0, 16'd5,    16'd30},   1'b1, '{8'hC0, 8'h42}},
      // a full lit/dark period, left to the model
      '{'{CMD_TICK,      3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 8'h00}},
      '{'{CMD_TICK,      3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 8'h00}},
      '{'{CMD_TICK,      3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 8'h00}},
      '{'{CMD_TICK,      3'd0, 1'b0, 16'h0000, 16'h0000}, 1'b0, '{8'h00, 8'h00}},
      '{'{CMD_BLINK,     3'd0, 1'b1, 16'h0000, 16'hFFFF}, 1'b0, '{8'h00, 8'h00}}
   };

   // DUT signals, all inputs known from time zero
   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic                 busy;
   logic [2:0]           req_command     = '0;
   logic [2:0]           req_led         = '0;
   logic                 req_level       = 1'b0;
   logic [15:0]          req_on_time_ms  = '0;
   logic [15:0]          req_off_time_ms = '0;
   logic                 csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [7:0]           csr_data        = '0;
   logic                 rsp_valid;
   logic [7:0]           rsp_pin_levels;
   logic [7:0]           rsp_blinking;

   // model of the LED row
   mode_type   mdl_mode   [LED_NUM];
   logic       mdl_lit    [LED_NUM];
   time_type   mdl_remain [LED_NUM];
   time_type   mdl_on_ms  [LED_NUM];
   time_type   mdl_off_ms [LED_NUM];
   logic [7:0] mdl_pins;
   logic [7:0] mdl_polarity;
   logic [7:0] mdl_step;

   led_status_type pending_status_q [$];   // statuses owed by the block, oldest first
   int             fail_count   = 0;
   int             stall_cycles = 0;

   multi_led_blink_controller_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_led         (req_led),
      .req_level       (req_level),
      .req_on_time_ms  (req_on_time_ms),
      .req_off_time_ms (req_off_time_ms),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_pin_levels  (rsp_pin_levels),
      .rsp_blinking    (rsp_blinking)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_led_row();
      int i;
      for (i = 0; i < LED_NUM; i++) begin
         mdl_mode[i]   = MODE_OFF;
         mdl_lit[i]    = 1'b0;
         mdl_remain[i] = '0;
         mdl_on_ms[i]  = '0;
         mdl_off_ms[i] = '0;
      end
      mdl_pins     = '0;
      mdl_polarity = 8'hFF;
      mdl_step     = 8'd10;
   endfunction

   // Apply one request to the model and return the status the block must report.
   function automatic led_status_type advance_led_row(input led_req_type r);
      led_status_type s;
      int             i;
      int             n;
      n = int'(r.led);
      if (r.command == CMD_TICK) begin
         for (i = 0; i < LED_NUM; i++) begin
            if (mdl_mode[i] == MODE_BLINK) begin
               // saturating countdown; a zero step still swaps an expired LED
               mdl_remain[i] = (mdl_remain[i] > time_type'(mdl_step))
                               ? mdl_remain[i] - time_type'(mdl_step) : '0;
               if (mdl_remain[i] == '0) begin
                  if (mdl_lit[i]) begin
                     mdl_pins[i] = ~mdl_polarity[i];
                     if (mdl_off_ms[i] == '0) begin
                        mdl_mode[i] = MODE_OFF;     // one-shot blink done
                     end else begin
                        mdl_remain[i] = mdl_off_ms[i];
                        mdl_lit[i]    = 1'b0;
                     end
                  end else begin
                     mdl_remain[i] = mdl_on_ms[i];
                     mdl_lit[i]    = 1'b1;
                     mdl_pins[i]   = mdl_polarity[i];
                  end
               end
            end
         end
      end else if (n < LED_NUM) begin
         case (r.command)
            CMD_SET_LEVEL: begin
               mdl_pins[n] = r.level;
            end
            CMD_ON: begin
               mdl_mode[n] = MODE_ON;
               mdl_pins[n] = mdl_polarity[n];
            end
            CMD_OFF: begin
               mdl_mode[n] = MODE_OFF;
               mdl_pins[n] = ~mdl_polarity[n];
            end
            CMD_TOGGLE: begin
               mdl_mode[n] = MODE_TOG;
               mdl_pins[n] = mdl_lit[n] ? ~mdl_polarity[n] : mdl_polarity[n];
               mdl_lit[n]  = ~mdl_lit[n];
            end
            CMD_BLINK: begin
               mdl_pins[n]   = mdl_polarity[n];
               mdl_lit[n]    = 1'b1;
               mdl_mode[n]   = MODE_BLINK;
               mdl_remain[n] = r.on_ms;
               mdl_on_ms[n]  = r.on_ms;
               mdl_off_ms[n] = r.off_ms;
            end
            default: begin
            end
         endcase
      end
      s.pin_levels = mdl_pins;
      for (i = 0; i < LED_NUM; i++) begin
         s.blinking[i] = (mdl_mode[i] == MODE_BLINK);
      end
      return s;
   endfunction

   // Mostly short times so blinks expire within a few ticks; some full-range.
   function automatic logic [15:0] random_ms();
      int k;
      k = $urandom_range(9);
      case (k)
         6:       return 16'h0000;
         7:       return 16'($urandom_range(65535));
         8:       return 16'hFFFF;
         9:       return 16'($urandom_range(300));
         default: return 16'($urandom_range(60));
      endcase
   endfunction

   function automatic led_req_type random_request();
      led_req_type r;
      int          sel;
      sel = $urandom_range(99);
      if (sel < 35) begin
         r.command = CMD_TICK;
      end else if (sel < 55) begin
         r.command = CMD_BLINK;
      end else if (sel < 63) begin
         r.command = CMD_ON;
      end else if (sel < 71) begin
         r.command = CMD_OFF;
      end else if (sel < 82) begin
         r.command = CMD_TOGGLE;
      end else if (sel < 96) begin
         r.command = CMD_SET_LEVEL;
      end else begin
         r.command = sel[0] ? CMD_RSVD7 : CMD_RSVD6;
      end
      r.led    = 3'($urandom_range(7));
      r.level  = 1'($urandom_range(1));
      r.on_ms  = random_ms();
      r.off_ms = random_ms();
      return r;
   endfunction

   // Present one request and hold it until the block takes it. start is left
   // high so a following request can go out back to back.
   task automatic issue_request(input led_req_type r, input logic typed,
                                input led_status_type known);
      led_status_type predicted;
      start           <= 1'b1;
      req_command     <= r.command;
      req_led         <= r.led;
      req_level       <= r.level;
      req_on_time_ms  <= r.on_ms;
      req_off_time_ms <= r.off_ms;
      @(posedge clock);
      while (busy) @(posedge clock);
      // taken at this edge
      predicted = advance_led_row(r);
      pending_status_q.push_back(typed ? known : predicted);
   endtask

   // Let every owed status come back, then give busy time to drop.
   task automatic drain_requests();
      start <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both registers, back to back, only while the block is idle.
   task automatic write_settings(input logic [7:0] polarity, input logic [7:0] step);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ON_POLARITY;
      csr_data     <= polarity;
      @(posedge clock);
      mdl_polarity = polarity;
      csr_index    <= CSR_TICK_STEP_MS;
      csr_data     <= step;
      @(posedge clock);
      mdl_step     = step;
      csr_write_en <= 1'b0;
   endtask

   // Response checker: one strobe, one status, compared with the oldest owed.
   always @(posedge clock) begin : check_status
      led_status_type owed;
      if (!reset && rsp_valid) begin
         if (pending_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
               $display("%0t: unexpected response pins=%h blinking=%h",
                        $time, rsp_pin_levels, rsp_blinking);
            end
         end else begin
            owed = pending_status_q.pop_front();
            if (rsp_pin_levels !== owed.pin_levels || rsp_blinking !== owed.blinking) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN) begin
                  $display("%0t: mismatch pins exp=%h got=%h, blinking exp=%h got=%h",
                           $time, owed.pin_levels, rsp_pin_levels,
                           owed.blinking, rsp_blinking);
               end
            end
         end
      end
   end

   // Watchdog: any request taken, response or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int          i;
      int          p;
      int          idle_pct;
      logic [7:0]  polarity;
      logic [7:0]  step;
      reset_led_row();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, back to back, at reset settings
      for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
         issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].status);
      end

      // random phases, settings rewritten between them while idle
      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin polarity = 8'h00; step = 8'd255; end
            1: begin polarity = 8'hFF; step = 8'd1;   end
            2: begin polarity = 8'h5A; step = 8'd0;   end   // zero step
            3: begin polarity = 8'hA5; step = 8'd10;  end
            default: begin
               polarity = 8'($urandom_range(255));
               step     = 8'($urandom_range(255, 1));
            end
         endcase
         // mix of heavy, light and no sender gaps; the last phase runs flat out
         if (p == NUM_PHASES - 1) begin
            idle_pct = 0;
         end else begin
            idle_pct = (p % 3 == 0) ? 50 : ((p % 3 == 1) ? 0 : 15);
         end
         drain_requests();
         write_settings(polarity, step);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            issue_request(random_request(), 1'b0, '0);
            if ($urandom_range(99) < idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(18, 1)) @(posedge clock);
            end
         end
      end

      drain_requests();
      repeat (LED_NUM + 6) @(posedge clock);
      if (fail_count == 0 && pending_status_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
